>>> hdl/blss_pkg.sv
// blss_pkg: shared types and constants for the bounded list store
// command and status codes, sequencer states, per-cell control word
// no dependencies
`default_nettype none

package blss_pkg;

   localparam int CMD_W  = 3;
   localparam int IDX_W  = 4;
   localparam int DATA_W = 32;
   localparam int POS_W  = 5;
   localparam int CNT_W  = 5;
   localparam int STS_W  = 2;

   localparam logic [POS_W-1:0] POS_NONE = '1;

   typedef enum logic [CMD_W-1:0] {
      CMD_APPEND = 3'd0,
      CMD_SET    = 3'd1,
      CMD_REMOVE = 3'd2,
      CMD_FIND   = 3'd3,
      CMD_READ   = 3'd4
   } blss_cmd_type;

   typedef enum logic [STS_W-1:0] {
      STS_OK    = 2'd0,
      STS_FULL  = 2'd1,
      STS_RANGE = 2'd2
   } blss_status_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_SCAN = 1'b1
   } blss_state_type;

   // broadcast to every cell; each cell works out its own action
   typedef struct packed {
      logic append;
      logic set;
      logic remove;
      logic capture;
      logic shift;
   } blss_cell_ctl_type;

endpackage

`default_nettype wire

>>> hdl/blss_req_if.sv
// blss_req_if: command channel of the list store, valid/ready handshake
// payload widths from blss_pkg
`default_nettype none

interface blss_req_if;
   import blss_pkg::*;

   logic                     valid;
   logic                     ready;
   logic [CMD_W-1:0]         cmd;
   logic [IDX_W-1:0]         index;
   logic signed [DATA_W-1:0] value;

   modport source (output valid, output cmd, output index, output value, input ready);
   modport sink   (input valid, input cmd, input index, input value, output ready);
endinterface

`default_nettype wire

>>> hdl/blss_rsp_if.sv
// blss_rsp_if: result channel of the list store, valid/ready handshake
// payload widths from blss_pkg
`default_nettype none

interface blss_rsp_if;
   import blss_pkg::*;

   logic                     valid;
   logic                     ready;
   logic [STS_W-1:0]         status;
   logic signed [DATA_W-1:0] data;
   logic signed [POS_W-1:0]  position;
   logic [CNT_W-1:0]         count;

   modport source (output valid, output status, output data, output position,
                   output count, input ready);
   modport sink   (input valid, input status, input data, input position,
                   input count, output ready);
endinterface

`default_nettype wire

>>> hdl/bounded_list_store_with_search_unit.sv
// bounded_list_store_with_search_unit: top level of the bounded list store
// instantiates blss_cell; uses blss_pkg, blss_req_if, blss_rsp_if
//
// usage
//   req channel carries one command word: cmd, index, value. rsp channel
//   returns exactly one result word per command: status, data, position, count.
//   the list lives in a row of CAPACITY cells; append, set, remove and read
//   act on all cells at once and finish in the cycle the command is taken,
//   so the result word is valid on the next cycle.
//   find captures a match flag in every cell, then the flags shift toward
//   cell 0 one place per cycle until a hit or the end of the list.
//   one command is in flight at a time; a new command is taken in the same
//   cycle the previous result word leaves (or while the result slot is empty),
//   so append/set/remove/read sustain one word per cycle while results are
//   taken, and find is bounded by the flag shift through the cell row.
//   a stalled receiver simply holds the result word in the output register;
//   req_ch.ready stays low until it is taken.
//   reset (synchronous, active high) empties the list (count zero) and clears
//   the result slot; entry contents are not cleared, no sweep is needed.
`default_nettype none

module bounded_list_store_with_search_unit #(
   parameter int CAPACITY = 16
) (
   input  wire logic    clock,
   input  wire logic    reset,
   blss_req_if.sink     req_ch,
   blss_rsp_if.source   rsp_ch
);
   import blss_pkg::*;

   // count width, and width for index versus count compares
   localparam int CW  = $clog2(CAPACITY + 1);
   localparam int IW  = (CW > IDX_W) ? CW : IDX_W;
   // only the first sixteen cells can be addressed by the index field
   localparam int RDN = (CAPACITY < (1 << IDX_W)) ? CAPACITY : (1 << IDX_W);

   // sequencer
   blss_state_type state_ff, state_in;
   logic           req_ready;
   logic           scan_active;

   // list bookkeeping
   logic [CW-1:0]  fill_ff, fill_in;
   logic [CW-1:0]  scan_ff, scan_in;

   // result register
   logic                rsp_valid_ff, rsp_valid_in;
   blss_status_type     status_ff, status_in;
   logic [DATA_W-1:0]   data_ff, data_in;
   logic [POS_W-1:0]    pos_ff, pos_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;

   // cell row
   logic [DATA_W-1:0]   ent [CAPACITY];
   logic                mat [CAPACITY];
   blss_cell_ctl_type   cell_ctl;

   // decode
   logic                accept;
   blss_cmd_type        cmd;
   logic [IW-1:0]       idx_ext;
   logic [IW-1:0]       fill_ext;
   logic                in_range;
   logic                full;
   logic [DATA_W-1:0]   rd_data;
   logic                scan_done;
   logic [CW+CNT_W-1:0] fill_wide;
   logic [CW+POS_W-1:0] scan_wide;

   assign accept   = req_ch.valid && req_ready;
   assign cmd      = blss_cmd_type'(req_ch.cmd);
   assign idx_ext  = IW'(req_ch.index);
   assign fill_ext = IW'(fill_ff);
   assign in_range = (idx_ext < fill_ext) && (idx_ext < IW'(CAPACITY));
   assign full     = (fill_ff == CW'(CAPACITY));

   // read port over the addressable cells
   always_comb begin
      rd_data = '0;
      for (int k = 0; k < RDN; k++) begin
         if (req_ch.index == IDX_W'(k)) begin
            rd_data = ent[k];
         end
      end
   end

   // per-cell commands, already qualified by range and full checks
   always_comb begin
      cell_ctl.append  = accept && (cmd == CMD_APPEND) && !full;
      cell_ctl.set     = accept && (cmd == CMD_SET) && in_range;
      cell_ctl.remove  = accept && (cmd == CMD_REMOVE) && in_range;
      cell_ctl.capture = accept && (cmd == CMD_FIND);
      cell_ctl.shift   = scan_active;
   end

   // row of cells, each takes entry and match flag from the one above
   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      logic [DATA_W-1:0] nxt_entry;
      logic              nxt_match;
      if (g < CAPACITY - 1) begin : g_mid
         assign nxt_entry = ent[g+1];
         assign nxt_match = mat[g+1];
      end else begin : g_end
         assign nxt_entry = '0;
         assign nxt_match = 1'b0;
      end
      blss_cell #(
         .POS (g),
         .CW  (CW),
         .IW  (IW)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (cell_ctl),
         .idx        (idx_ext),
         .fill       (fill_ff),
         .key        (req_ch.value),
         .next_entry (nxt_entry),
         .next_match (nxt_match),
         .entry      (ent[g]),
         .match      (mat[g])
      );
   end

   // scan ends on a hit in cell 0 or once every live cell has passed
   assign scan_done = scan_active && (mat[0] || (scan_ff == fill_ff));

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && (cmd == CMD_FIND)) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (scan_done) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_ready   = 1'b0;
      scan_active = 1'b0;
      case (state_ff)
         ST_IDLE: req_ready   = !rsp_valid_ff || rsp_ch.ready;
         ST_SCAN: scan_active = 1'b1;
         default: begin
            req_ready   = 1'b0;
            scan_active = 1'b0;
         end
      endcase
   end

   // fill count and scan position
   always_comb begin
      fill_in = fill_ff;
      if (cell_ctl.append) begin
         fill_in = fill_ff + 1'b1;
      end else if (cell_ctl.remove) begin
         fill_in = fill_ff - 1'b1;
      end
      scan_in = scan_ff;
      if (cell_ctl.capture) begin
         scan_in = '0;
      end else if (scan_active && !scan_done) begin
         scan_in = scan_ff + 1'b1;
      end
   end

   // counts wider than the result fields are masked to them
   assign fill_wide = {{CNT_W{1'b0}}, fill_in};
   assign scan_wide = {{POS_W{1'b0}}, scan_ff};

   // result word
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      status_in    = status_ff;
      data_in      = data_ff;
      pos_in       = pos_ff;
      cnt_in       = cnt_ff;
      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (accept && (cmd != CMD_FIND)) begin
         rsp_valid_in = 1'b1;
         status_in    = STS_OK;
         data_in      = '0;
         pos_in       = '0;
         cnt_in       = fill_wide[CNT_W-1:0];
         case (cmd)
            CMD_APPEND: begin
               if (full) begin
                  status_in = STS_FULL;
               end
            end
            CMD_SET: begin
               if (!in_range) begin
                  status_in = STS_RANGE;
               end
            end
            CMD_REMOVE, CMD_READ: begin
               if (in_range) begin
                  data_in = rd_data;
               end else begin
                  status_in = STS_RANGE;
               end
            end
            default: begin
               status_in = STS_OK;
            end
         endcase
      end else if (scan_done) begin
         rsp_valid_in = 1'b1;
         status_in    = STS_OK;
         data_in      = '0;
         pos_in       = mat[0] ? scan_wide[POS_W-1:0] : POS_NONE;
         cnt_in       = fill_wide[CNT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         scan_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         scan_ff      <= scan_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
      data_ff   <= data_in;
      pos_ff    <= pos_in;
      cnt_ff    <= cnt_in;
   end

   assign req_ch.ready    = req_ready;
   assign rsp_ch.valid    = rsp_valid_ff;
   assign rsp_ch.status   = status_ff;
   assign rsp_ch.data     = data_ff;
   assign rsp_ch.position = pos_ff;
   assign rsp_ch.count    = cnt_ff;

   // list never holds more than its capacity
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CW'(CAPACITY))
      else $error("fill count above capacity");

   // scan pointer never runs past the live entries
   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      scan_active |-> (scan_ff <= fill_ff))
      else $error("scan pointer beyond fill count");

   // result slot is empty for the whole scan
   a_scan_slot: assert property (@(posedge clock) disable iff (reset)
      scan_active |-> !rsp_valid_ff)
      else $error("result word pending during find scan");

   // a command other than find answers on the next cycle
   a_one_cycle: assert property (@(posedge clock) disable iff (reset)
      (accept && (cmd != CMD_FIND)) |=> (rsp_valid_ff && (state_ff == ST_IDLE)))
      else $error("missing result word after single-cycle command");

   // a finished scan always leaves a result word behind
   a_scan_result: assert property (@(posedge clock) disable iff (reset)
      scan_done |=> (rsp_valid_ff && !scan_active))
      else $error("find scan ended without a result word");

endmodule

`default_nettype wire

>>> hdl/blss_cell.sv
// blss_cell: one list slot, holds an entry and a find-match flag
// shifts entry and flag from its upper neighbor; uses blss_pkg
`default_nettype none

module blss_cell #(
   parameter int POS = 0,
   parameter int CW  = 5,
   parameter int IW  = 5
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire blss_pkg::blss_cell_ctl_type    ctl,
   input  wire logic [IW-1:0]                  idx,
   input  wire logic [CW-1:0]                  fill,
   input  wire logic [blss_pkg::DATA_W-1:0]    key,
   input  wire logic [blss_pkg::DATA_W-1:0]    next_entry,
   input  wire logic                           next_match,
   output logic [blss_pkg::DATA_W-1:0]         entry,
   output logic                                match
);
   import blss_pkg::*;

   localparam logic [CW:0] MY_C = (CW+1)'(POS);
   localparam logic [IW:0] MY_I = (IW+1)'(POS);

   logic [DATA_W-1:0] entry_ff, entry_in;
   logic              match_ff, match_in;
   logic              live;

   assign live = MY_C < {1'b0, fill};

   always_comb begin
      entry_in = entry_ff;
      if (ctl.append && ({1'b0, fill} == MY_C)) begin
         entry_in = key;
      end else if (ctl.set && ({1'b0, idx} == MY_I)) begin
         entry_in = key;
      end else if (ctl.remove && (MY_I >= {1'b0, idx}) && ((MY_C + 1'b1) < {1'b0, fill})) begin
         entry_in = next_entry;
      end
   end

   always_comb begin
      match_in = match_ff;
      if (ctl.capture) begin
         match_in = live && (entry_ff == key);
      end else if (ctl.shift) begin
         match_in = next_match;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         match_ff <= 1'b0;
      end else begin
         match_ff <= match_in;
      end
   end

   assign entry = entry_ff;
   assign match = match_ff;
endmodule

`default_nettype wire
